### hdl/gct_pkg.sv
package gct_pkg;

   localparam int MaxCellWidth  = 64;
   localparam int MaxCellHeight = 64;
   localparam int GroupW        = 8;
   localparam int Groups        = MaxCellWidth / GroupW;

   localparam logic [1:0] CSR_CELL_WIDTH       = 2'd0;
   localparam logic [1:0] CSR_CELL_HEIGHT      = 2'd1;
   localparam logic [1:0] CSR_ALPHA_THRESHOLD  = 2'd2;
   localparam logic [1:0] CSR_FIXED_WIDTH_MODE = 2'd3;

   typedef struct packed {
      logic [6:0] cell_width;
      logic [6:0] cell_height;
      logic [7:0] alpha_threshold;
      logic       fixed_width_mode;
   } cfg_type;

   typedef struct packed {
      logic [MaxCellWidth-1:0] mask;
      logic                    fixed;
      logic [6:0]              width;
   } cell_done_type;

   typedef struct packed {
      logic [Groups-1:0]       any;
      logic [Groups-1:0][2:0]  lo;
      logic [Groups-1:0][2:0]  hi;
      logic                    fixed;
      logic [6:0]              width;
   } group_scan_type;

   typedef struct packed {
      logic        blank_cell;
      logic [5:0]  last_column;
      logic [5:0]  first_column;
      logic [6:0]  advance;
      logic signed [6:0] left_offset;
   } result_type;

endpackage

### hdl/gct_cell_track.sv
module gct_cell_track import gct_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [7:0]    alpha,
   input  logic          force_fixed,
   output logic          done_valid,
   output cell_done_type done
);

   logic [MaxCellWidth-1:0] inked_ff, inked_in, inked_now, wmask;
   logic [5:0] col_ff, col_in, row_ff, row_in;
   logic       fixed_ff, fixed_in, fixed_now;
   logic [6:0] w, h;
   logic       acc, first, col_last, row_last, cell_end;

   always_comb begin
      if (cfg.cell_width == 7'd0) begin
         w = 7'd1;
      end else if (cfg.cell_width > 7'(MaxCellWidth)) begin
         w = 7'(MaxCellWidth);
      end else begin
         w = cfg.cell_width;
      end
      if (cfg.cell_height == 7'd0) begin
         h = 7'd1;
      end else if (cfg.cell_height > 7'(MaxCellHeight)) begin
         h = 7'(MaxCellHeight);
      end else begin
         h = cfg.cell_height;
      end
      for (int i = 0; i < MaxCellWidth; i++) begin
         wmask[i] = (7'(i) < w);
      end
   end

   assign acc       = req_tvalid && req_tready;
   assign first     = (col_ff == 6'd0) && (row_ff == 6'd0);
   assign fixed_now = first ? (force_fixed | cfg.fixed_width_mode) : fixed_ff;
   assign inked_now = inked_ff |
                      ((alpha > cfg.alpha_threshold) ? (64'd1 << col_ff) : 64'd0);
   assign col_last  = ({1'b0, col_ff} + 7'd1) >= w;
   assign row_last  = ({1'b0, row_ff} + 7'd1) >= h;
   assign cell_end  = col_last && row_last;

   always_comb begin
      inked_in = inked_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      fixed_in = fixed_ff;
      if (acc) begin
         if (cell_end) begin
            inked_in = '0;
            col_in   = 6'd0;
            row_in   = 6'd0;
            fixed_in = 1'b0;
         end else begin
            inked_in = inked_now;
            fixed_in = fixed_now;
            col_in   = col_last ? 6'd0 : col_ff + 6'd1;
            row_in   = col_last ? row_ff + 6'd1 : row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inked_ff <= '0;
         col_ff   <= 6'd0;
         row_ff   <= 6'd0;
         fixed_ff <= 1'b0;
      end else begin
         inked_ff <= inked_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         fixed_ff <= fixed_in;
      end
   end

   assign done_valid = acc && cell_end;
   assign done.mask  = inked_now & wmask;
   assign done.fixed = fixed_now;
   assign done.width = w;

   a_cell_clear: assert property (@(posedge clock) disable iff (reset)
      acc && cell_end |=> col_ff == 6'd0 && row_ff == 6'd0 && inked_ff == '0)
      else $error("cell state not cleared after last beat");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      acc && !col_last |=> col_ff == $past(col_ff) + 6'd1)
      else $error("column counter did not step");

endmodule

### hdl/gct_group_scan.sv
module gct_group_scan import gct_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  cell_done_type  in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output group_scan_type out_data
);

   logic           v_ff, v_in;
   group_scan_type data_ff, data_in;
   logic [GroupW-1:0] bits;

   always_comb begin
      data_in.fixed = in_data.fixed;
      data_in.width = in_data.width;
      for (int g = 0; g < Groups; g++) begin
         bits = in_data.mask[g*GroupW +: GroupW];
         data_in.any[g] = |bits;
         data_in.lo[g]  = 3'd0;
         data_in.hi[g]  = 3'd0;
         for (int i = GroupW - 1; i >= 0; i--) begin
            if (bits[i]) begin
               data_in.lo[g] = 3'(i);
            end
         end
         for (int i = 0; i < GroupW; i++) begin
            if (bits[i]) begin
               data_in.hi[g] = 3'(i);
            end
         end
      end
   end

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff && !out_ready |=> v_ff && $stable(data_ff))
      else $error("stalled group scan lost its data");

endmodule

### hdl/gct_edge_merge.sv
module gct_edge_merge import gct_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  group_scan_type in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output result_type     out_data
);

   logic       v_ff, v_in;
   result_type res_ff, res_in;
   logic [5:0] left, right;
   logic       blank;

   always_comb begin
      left  = 6'd0;
      right = 6'd0;
      for (int g = Groups - 1; g >= 0; g--) begin
         if (in_data.any[g]) begin
            left = {3'(g), in_data.lo[g]};
         end
      end
      for (int g = 0; g < Groups; g++) begin
         if (in_data.any[g]) begin
            right = {3'(g), in_data.hi[g]};
         end
      end
      blank = ~|in_data.any;

      res_in.left_offset  = 7'sd0;
      res_in.first_column = 6'd0;
      res_in.last_column  = 6'd0;
      res_in.blank_cell   = 1'b0;
      if (in_data.fixed) begin
         res_in.advance = in_data.width;
      end else if (blank) begin
         res_in.advance    = in_data.width + 7'd1;
         res_in.blank_cell = 1'b1;
      end else begin
         res_in.left_offset  = 7'd0 - {1'b0, left};
         res_in.advance      = {1'b0, right} - {1'b0, left} + 7'd2;
         res_in.first_column = left;
         res_in.last_column  = right;
      end
   end

   assign in_ready = !v_ff || out_ready;
   assign v_in     = in_ready ? in_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = v_ff;
   assign out_data  = res_ff;

   a_blank_zero: assert property (@(posedge clock) disable iff (reset)
      v_ff && res_ff.blank_cell |-> res_ff.first_column == 6'd0
         && res_ff.last_column == 6'd0 && res_ff.left_offset == 7'sd0)
      else $error("blank cell carries column data");

   a_order: assert property (@(posedge clock) disable iff (reset)
      v_ff |-> res_ff.first_column <= res_ff.last_column)
      else $error("first column past last column");

endmodule

### hdl/glyph_column_trim.sv
// Horizontal trim of glyph cells by alpha coverage. Send the alpha bytes of
// a cell in row-major order, one per beat; force_fixed is sampled on the
// first beat of a cell. While rsp is not back-pressured, one pixel is taken
// every cycle with no gap between cells; the metrics beat of a cell passes
// the column flag scan register, then the result register, and cells as
// small as one pixel still run at one result per cycle. Back-pressure on
// rsp stalls the whole pipe. Out-of-range sizes saturate to 1..64; write
// the csr registers only while no cell is in progress.
module glyph_column_trim import gct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] alpha
   input  logic        req_tuser,   // [0] force_fixed
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] left_offset, [13:7] advance,
                                    // [19:14] first_column, [25:20] last_column
   output logic        rsp_tuser,   // [0] blank_cell
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           done_valid, scan_ready, scan_valid, merge_ready;
   cell_done_type  done;
   group_scan_type scan;
   result_type     res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CELL_WIDTH:       cfg_in.cell_width       = csr_wdata[6:0];
            CSR_CELL_HEIGHT:      cfg_in.cell_height      = csr_wdata[6:0];
            CSR_ALPHA_THRESHOLD:  cfg_in.alpha_threshold  = csr_wdata;
            CSR_FIXED_WIDTH_MODE: cfg_in.fixed_width_mode = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_width       <= 7'd8;
         cfg_ff.cell_height      <= 7'd8;
         cfg_ff.alpha_threshold  <= 8'd64;
         cfg_ff.fixed_width_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = scan_ready;

   gct_cell_track u_track (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .alpha       (req_tdata),
      .force_fixed (req_tuser),
      .done_valid  (done_valid),
      .done        (done)
   );

   gct_group_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (done_valid),
      .in_ready  (scan_ready),
      .in_data   (done),
      .out_valid (scan_valid),
      .out_ready (merge_ready),
      .out_data  (scan)
   );

   gct_edge_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scan_valid),
      .in_ready  (merge_ready),
      .in_data   (scan),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {6'd0, res.last_column, res.first_column, res.advance,
                       res.left_offset};
   assign rsp_tuser = res.blank_cell;

endmodule

### bench/glyph_column_trim_tb.sv
module glyph_column_trim_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gct_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] alpha
   logic        req_tuser;   // [0] force_fixed
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [6:0] left_offset, [13:7] advance,
                             // [19:14] first_column, [25:20] last_column
   logic        rsp_tuser;   // [0] blank_cell
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   glyph_column_trim DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // shadow of the registers and of the cell being collected
   cfg_type     shadow;
   logic [63:0] inked_cols;
   int          col_pos;
   int          row_pos;
   logic        cell_is_fixed;

   result_type  metrics_due[$];
   int          mismatches;
   int          pixels_sent;
   int          n_cells, n_fixed, n_blank, n_trimmed, n_settings, widest;
   bit          send_idle;
   bit          drain_idle;

   function automatic int eff_width();
      if (shadow.cell_width == 7'd0) return 1;
      if (shadow.cell_width > MaxCellWidth) return MaxCellWidth;
      return int'(shadow.cell_width);
   endfunction

   function automatic int eff_height();
      if (shadow.cell_height == 7'd0) return 1;
      if (shadow.cell_height > MaxCellHeight) return MaxCellHeight;
      return int'(shadow.cell_height);
   endfunction

   // advance the shadow cell by one pixel; queue the metrics on its last pixel
   task automatic absorb_pixel(input logic [7:0] alpha, input logic force_fx);
      int          w, h, left, right;
      logic [63:0] live;
      result_type  r;
      w = eff_width();
      h = eff_height();
      if (col_pos == 0 && row_pos == 0)
         cell_is_fixed = force_fx | shadow.fixed_width_mode;
      if (alpha > shadow.alpha_threshold)
         inked_cols[col_pos] = 1'b1;
      if (col_pos + 1 < w) begin
         col_pos++;
         return;
      end
      col_pos = 0;
      if (row_pos + 1 < h) begin
         row_pos++;
         return;
      end
      live = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
      live &= inked_cols;
      r = '0;
      if (cell_is_fixed) begin
         r.advance = 7'(w);
         n_fixed++;
      end else if (live == '0) begin
         r.advance    = 7'(w + 1);
         r.blank_cell = 1'b1;
         n_blank++;
      end else begin
         left = 0;
         while (left < 63 && !live[left]) left++;
         right = 63;
         while (right > left && !live[right]) right--;
         r.left_offset  = 7'(128 - left);
         r.advance      = 7'(right - left + 2);
         r.first_column = 6'(left);
         r.last_column  = 6'(right);
         n_trimmed++;
      end
      metrics_due = {metrics_due, r};
      n_cells++;
      if (w > widest) widest = w;
      inked_cols    = '0;
      row_pos       = 0;
      cell_is_fixed = 1'b0;
   endtask

   task automatic note_mismatch(input string what, input result_type want,
                                input result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%0t %s: want off=%0d adv=%0d first=%0d last=%0d blank=%0b",
                $realtime, what, want.left_offset, want.advance, want.first_column,
                want.last_column, want.blank_cell);
         $display(" | got off=%0d adv=%0d first=%0d last=%0d blank=%0b",
                  got.left_offset, got.advance, got.first_column, got.last_column,
                  got.blank_cell);
      end
   endtask

   result_type got_beat, want_beat;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat.left_offset  = rsp_tdata[6:0];
         got_beat.advance      = rsp_tdata[13:7];
         got_beat.first_column = rsp_tdata[19:14];
         got_beat.last_column  = rsp_tdata[25:20];
         got_beat.blank_cell   = rsp_tuser;
         if (metrics_due.size() == 0) begin
            note_mismatch("unexpected beat", '0, got_beat);
         end else begin
            want_beat = metrics_due.pop_front();
            if (got_beat !== want_beat)
               note_mismatch("metrics mismatch", want_beat, got_beat);
         end
      end
   end

   // receiver: random stall before each beat while drain_idle is set
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = drain_idle ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   task automatic send_pixel(input logic [7:0] alpha, input logic force_fx);
      int gap;
      gap = send_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = alpha;
      req_tuser  = force_fx;
      do @(posedge clock); while (!req_tready);
      absorb_pixel(alpha, force_fx);
      pixels_sent++;
      @(negedge clock);
   endtask

   // one whole cell; only columns lo..hi can carry ink, solid inks every pixel there unless the threshold is 255
   task automatic send_cell(input int lo, input int hi, input bit force_fx, input bit solid);
      int         w, h;
      logic [7:0] thr, a;
      w   = eff_width();
      h   = eff_height();
      thr = shadow.alpha_threshold;
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            if (c >= lo && c <= hi && thr != 8'hFF) begin
               if (solid) a = 8'($urandom_range(int'(thr) + 1, 255));
               else case ($urandom_range(0, 3))
                  0: a = thr + 8'd1;
                  1: a = 8'hFF;
                  2: a = 8'($urandom_range(0, 255));
                  default: a = 8'($urandom_range(0, int'(thr)));
               endcase
            end else if ($urandom_range(0, 7) == 0) begin
               a = thr;
            end else begin
               a = 8'($urandom_range(0, int'(thr)));
            end
            send_pixel(a, (r == 0 && c == 0) ? force_fx : 1'($urandom_range(0, 1)));
         end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (metrics_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [7:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_CELL_WIDTH:       shadow.cell_width       = value[6:0];
         CSR_CELL_HEIGHT:      shadow.cell_height      = value[6:0];
         CSR_ALPHA_THRESHOLD:  shadow.alpha_threshold  = value;
         CSR_FIXED_WIDTH_MODE: shadow.fixed_width_mode = value[0];
         default: ;
      endcase
   endtask

   task automatic test_default_cell();
      send_cell(2, 5, 1'b0, 1'b1);
      send_cell(8, 0, 1'b0, 1'b0);
   endtask

   // zero sizes saturate to one pixel per cell, one result per beat
   task automatic test_single_pixel();
      wait_drained();
      set_reg(CSR_CELL_WIDTH, 8'd0);
      set_reg(CSR_CELL_HEIGHT, 8'd0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd64, 1'b0);
      send_pixel(8'd65, 1'b0);
      send_pixel(8'd255, 1'b1);
   endtask

   task automatic test_threshold_extremes();
      wait_drained();
      set_reg(CSR_ALPHA_THRESHOLD, 8'd255);
      send_pixel(8'd255, 1'b0);
      wait_drained();
      set_reg(CSR_ALPHA_THRESHOLD, 8'd0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd1, 1'b0);
   endtask

   task automatic test_fixed_mode();
      wait_drained();
      set_reg(CSR_FIXED_WIDTH_MODE, 8'd1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      wait_drained();
      set_reg(CSR_FIXED_WIDTH_MODE, 8'd0);
   endtask

   // force_fixed counts on the first pixel of a cell only
   task automatic test_first_pixel_latch();
      wait_drained();
      set_reg(CSR_CELL_WIDTH, 8'd5);
      set_reg(CSR_CELL_HEIGHT, 8'd1);
      set_reg(CSR_ALPHA_THRESHOLD, 8'd64);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd90, 1'b1);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd0, 1'b0);
   endtask

   task automatic test_full_width();
      wait_drained();
      set_reg(CSR_CELL_WIDTH, 8'd127);
      set_reg(CSR_CELL_HEIGHT, 8'd1);
      send_cell(63, 63, 1'b0, 1'b1);
      send_cell(0, 63, 1'b0, 1'b1);
      send_cell(64, 0, 1'b0, 1'b0);
      send_cell(0, 63, 1'b1, 1'b1);
   endtask

   task automatic randomize_settings();
      logic [6:0] w, h;
      logic [7:0] thr;
      case ($urandom_range(0, 9))
         0:       w = 7'd0;
         1:       w = 7'd64;
         2:       w = 7'($urandom_range(65, 127));
         3:       w = 7'd1;
         4:       w = 7'($urandom_range(13, 63));
         default: w = 7'($urandom_range(1, 12));
      endcase
      if (w > 16)
         h = 7'($urandom_range(0, 2));
      else if (w <= 2 && $urandom_range(0, 2) == 0)
         h = $urandom_range(0, 1) ? 7'd64 : 7'($urandom_range(65, 127));
      else
         h = 7'($urandom_range(0, 6));
      case ($urandom_range(0, 5))
         0:       thr = 8'd0;
         1:       thr = 8'd255;
         default: thr = 8'($urandom_range(0, 255));
      endcase
      set_reg(CSR_CELL_WIDTH, {1'($urandom_range(0, 1)), w});
      set_reg(CSR_CELL_HEIGHT, {1'($urandom_range(0, 1)), h});
      set_reg(CSR_ALPHA_THRESHOLD, thr);
      set_reg(CSR_FIXED_WIDTH_MODE,
              {7'($urandom_range(0, 127)), 1'($urandom_range(0, 3) == 0)});
      n_settings++;
   endtask

   task automatic test_random_cells(input int pixel_goal);
      int w, lo, hi;
      while (pixels_sent < pixel_goal) begin
         wait_drained();
         randomize_settings();
         send_idle  = $urandom_range(0, 3) != 0;
         drain_idle = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(3, 10)) begin
            if (pixels_sent >= pixel_goal) break;
            w = eff_width();
            if ($urandom_range(0, 5) == 0) begin
               lo = w;
               hi = 0;
            end else begin
               lo = $urandom_range(0, w - 1);
               hi = $urandom_range(lo, w - 1);
            end
            send_cell(lo, hi, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_CELL_WIDTH;
      csr_wdata     = '0;
      shadow        = '{cell_width: 7'd8, cell_height: 7'd8, alpha_threshold: 8'd64,
                        fixed_width_mode: 1'b0};
      inked_cols    = '0;
      col_pos       = 0;
      row_pos       = 0;
      cell_is_fixed = 1'b0;
      send_idle     = 1'b0;
      drain_idle    = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_default_cell();
      test_single_pixel();
      test_threshold_extremes();
      test_fixed_mode();
      test_first_pixel_latch();
      test_full_width();
      test_random_cells(1700);

      wait_drained();
      repeat (8) @(negedge clock);
      while (metrics_due.size() != 0)
         note_mismatch("missing beat", metrics_due.pop_front(), '0);
      $display("Checked %0d cells over %0d pixels: %0d fixed, %0d blank, %0d trimmed.",
               n_cells, pixels_sent, n_fixed, n_blank, n_trimmed);
      $display("Widths up to %0d across %0d random register settings; %0d mismatches.",
               widest, n_settings, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
